@@ design/pacs_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and saturation helpers for the polygon area block
// no dependencies
package pacs_pkg;

   localparam int CFB         = 16;          // fractional bits of a coordinate
   localparam int QUEUE_DEPTH = 4;           // edge queue between front and back
   localparam int CS_W        = 64 - CFB;    // significant bits of a scaled cross product
   localparam int CS_HI_W     = CS_W - 32;   // upper slice of it

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [31:0] area;
      logic signed [31:0] centroid_x;
      logic signed [31:0] centroid_y;
      logic [30:0]        perimeter;
      logic               degenerate;
   } rsp_type;

   // one edge p -> q as handed from front to back
   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      logic               first_edge;
      logic               close_edge;
   } edge_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [65:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [32:0] mag;
   } div_rsp_type;

   function automatic logic signed [63:0] sat64(input logic signed [98:0] v);
      if ((v[98:63] == '0) || (v[98:63] == '1)) begin
         return v[63:0];
      end else if (v[98]) begin
         return {1'b1, 63'd0};
      end else begin
         return {1'b0, {63{1'b1}}};
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if ((v[63:31] == '0) || (v[63:31] == '1)) begin
         return v[31:0];
      end else if (v[63]) begin
         return {1'b1, 31'd0};
      end else begin
         return {1'b0, {31{1'b1}}};
      end
   endfunction

endpackage

@@ design/pacs_front.sv @@
`timescale 1ns / 1ps
// front end: takes vertices, tracks first and previous vertex, emits edges
// depends on pacs_pkg
module pacs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pacs_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              push,
   output pacs_pkg::edge_type push_data
);

   logic               in_poly_ff, in_poly_in;
   logic               pend_first_ff, pend_first_in;
   logic               close_pend_ff, close_pend_in;
   logic signed [31:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [31:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic               accept;

   assign req_ready = !queue_full && !close_pend_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_poly_in    = in_poly_ff;
      pend_first_in = pend_first_ff;
      close_pend_in = close_pend_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      push          = 1'b0;
      push_data     = '{px: prev_x_ff, py: prev_y_ff, qx: req_data.vertex_x,
                        qy: req_data.vertex_y, first_edge: pend_first_ff, close_edge: 1'b0};
      if (close_pend_ff) begin
         // closing edge back to the first vertex
         push_data = '{px: prev_x_ff, py: prev_y_ff, qx: first_x_ff, qy: first_y_ff,
                       first_edge: 1'b0, close_edge: 1'b1};
         if (!queue_full) begin
            push          = 1'b1;
            close_pend_in = 1'b0;
         end
      end else if (accept) begin
         prev_x_in = req_data.vertex_x;
         prev_y_in = req_data.vertex_y;
         if (in_poly_ff) begin
            push          = 1'b1;
            pend_first_in = 1'b0;
            if (req_data.last_vertex) begin
               close_pend_in = 1'b1;
               in_poly_in    = 1'b0;
            end
         end else begin
            first_x_in = req_data.vertex_x;
            first_y_in = req_data.vertex_y;
            if (req_data.last_vertex) begin
               // single vertex: edge to itself, opens and closes the polygon
               push      = 1'b1;
               push_data = '{px: req_data.vertex_x, py: req_data.vertex_y,
                             qx: req_data.vertex_x, qy: req_data.vertex_y,
                             first_edge: 1'b1, close_edge: 1'b1};
            end else begin
               in_poly_in    = 1'b1;
               pend_first_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_poly_ff    <= 1'b0;
         pend_first_ff <= 1'b0;
         close_pend_ff <= 1'b0;
      end else begin
         in_poly_ff    <= in_poly_in;
         pend_first_ff <= pend_first_in;
         close_pend_ff <= close_pend_in;
      end
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
   end

endmodule

@@ design/pacs_fifo.sv @@
`timescale 1ns / 1ps
// short edge queue between front and back
// depends on pacs_pkg
module pacs_fifo #(
   parameter int QUEUE_DEPTH = pacs_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pacs_pkg::edge_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output pacs_pkg::edge_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pacs_pkg::edge_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("edge queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("edge queue read while empty");

endmodule

@@ design/pacs_div.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit a cycle, quotient clamped at 2^32
// depends on pacs_pkg
module pacs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pacs_pkg::div_req_type div_req,
   output pacs_pkg::div_rsp_type div_rsp
);

   localparam int ITER  = 64 + pacs_pkg::CFB;
   localparam int CNT_W = $clog2(ITER + 1);

   logic             busy_ff, done_ff, sticky_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [63:0]      num_ff;
   logic [65:0]      den_ff, rem_ff;
   logic [33:0]      q_ff;
   logic [66:0]      rem_n;
   logic             ge;

   assign rem_n = {rem_ff, num_ff[63]};
   assign ge    = (rem_n >= {1'b0, den_ff});

   assign div_rsp.done = done_ff;
   assign div_rsp.mag  = (sticky_ff || (q_ff > 34'h1_0000_0000)) ? 33'h1_0000_0000 : q_ff[32:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !div_req.start && busy_ff && (cnt_ff == CNT_W'(1));
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CNT_W'(1))) begin
            busy_ff <= 1'b0;
         end
      end
      if (div_req.start) begin
         cnt_ff    <= CNT_W'(ITER);
         num_ff    <= div_req.num;
         den_ff    <= div_req.den;
         rem_ff    <= '0;
         q_ff      <= '0;
         sticky_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff    <= cnt_ff - 1'b1;
         num_ff    <= {num_ff[62:0], 1'b0};
         rem_ff    <= ge ? 66'(rem_n - {1'b0, den_ff}) : rem_n[65:0];
         q_ff      <= {q_ff[32:0], ge};
         sticky_ff <= sticky_ff | q_ff[33];
      end
   end

endmodule

@@ design/pacs_back.sv @@
`timescale 1ns / 1ps
// back end: per-edge cross, moment and length terms on a shared multiplier,
// bit-serial square root, polygon close-out with area, centroid and perimeter
// depends on pacs_pkg, uses pacs_div through the top level
module pacs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pacs_pkg::edge_type    job_data,
   input  logic                  job_empty,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pacs_pkg::rsp_type     rsp_data,
   output pacs_pkg::div_req_type div_req,
   input  pacs_pkg::div_rsp_type div_rsp
);

   localparam int CFB     = pacs_pkg::CFB;
   localparam int CS_W    = pacs_pkg::CS_W;
   localparam int CS_HI_W = pacs_pkg::CS_HI_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_SQRT, ST_ACCUM, ST_FIN, ST_DIVX, ST_DIVY, ST_OUT
   } state_type;

   state_type          state_ff;
   logic [3:0]         step_ff;
   pacs_pkg::edge_type job_ff;
   logic signed [65:0] prod_ff, p0_ff, t_ff;
   logic signed [63:0] c_ff, mxt_ff, myt_ff;
   logic [63:0]        sx_ff;
   logic [64:0]        sq_ff;
   logic [32:0]        res_ff;
   logic [35:0]        rem_ff;
   logic [5:0]         idx_ff;
   logic signed [63:0] cross_ff, mx_ff, my_ff;
   logic [47:0]        len_ff;
   logic signed [31:0] cx_ff, cy_ff;
   logic               rsp_valid_ff;
   pacs_pkg::rsp_type  rsp_ff;
   pacs_pkg::div_req_type div_req_ff;

   logic signed [32:0] dx, dy, sumx, sumy, mul_a, mul_b;
   logic signed [65:0] prod;
   logic signed [CS_W-1:0] cs;
   logic [31:0]        cs_lo;
   logic [CS_HI_W-1:0] cs_hi;
   logic signed [98:0] term_wide, diff_wide;
   logic [65:0]        sq_pad;
   logic [1:0]         pair;
   logic [35:0]        rem_n, trial;
   logic [48:0]        len_n;
   logic [63:0]        uc, umx, umy;
   logic signed [63:0] area_wide;
   logic               degen;

   assign dx   = 33'(job_ff.qx) - 33'(job_ff.px);
   assign dy   = 33'(job_ff.qy) - 33'(job_ff.py);
   assign sumx = 33'(job_ff.qx) + 33'(job_ff.px);
   assign sumy = 33'(job_ff.qy) + 33'(job_ff.py);
   assign cs    = CS_W'(c_ff >>> CFB);
   assign cs_lo = cs[31:0];
   assign cs_hi = cs[CS_W-1:32];

   // operand select for the one shared 33 x 33 multiplier
   always_comb begin
      unique case (step_ff)
         4'd0:    begin mul_a = 33'(job_ff.px); mul_b = 33'(job_ff.qy); end
         4'd1:    begin mul_a = 33'(job_ff.py); mul_b = 33'(job_ff.qx); end
         4'd2:    begin mul_a = dx; mul_b = dx; end
         4'd3:    begin mul_a = dy; mul_b = dy; end
         4'd4:    begin mul_a = {1'b0, cs_lo}; mul_b = sumx; end
         4'd5:    begin mul_a = 33'(signed'(cs_hi)); mul_b = sumx; end
         4'd6:    begin mul_a = {1'b0, cs_lo}; mul_b = sumy; end
         4'd7:    begin mul_a = 33'(signed'(cs_hi)); mul_b = sumy; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign term_wide = ({{33{prod_ff[65]}}, prod_ff} <<< 32) + {{33{t_ff[65]}}, t_ff};
   assign diff_wide = {{33{p0_ff[65]}}, p0_ff} - {{33{prod_ff[65]}}, prod_ff};

   // square root, two radicand bits a step
   assign sq_pad = {1'b0, sq_ff};
   assign pair   = sq_pad[{idx_ff, 1'b0} +: 2];
   assign rem_n  = {rem_ff[33:0], pair};
   assign trial  = {1'b0, res_ff, 2'b01};
   assign len_n  = {1'b0, len_ff} + {16'd0, res_ff};

   assign uc  = cross_ff[63] ? 64'(-cross_ff) : 64'(cross_ff);
   assign umx = mx_ff[63] ? 64'(-mx_ff) : 64'(mx_ff);
   assign umy = my_ff[63] ? 64'(-my_ff) : 64'(my_ff);
   assign area_wide = cross_ff >>> (CFB + 1);
   assign degen     = (cross_ff == '0);

   function automatic logic signed [31:0] signed_mag(input logic [32:0] m, input logic neg);
      if (neg) begin
         return (m >= 33'h0_8000_0000) ? {1'b1, 31'd0} : 32'(-m);
      end else begin
         return (m > 33'h0_7FFF_FFFF) ? {1'b0, {31{1'b1}}} : m[31:0];
      end
   endfunction

   assign job_pop   = (state_ff == ST_IDLE) && !job_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign div_req   = div_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start <= ((state_ff == ST_FIN) && !degen) ||
                             ((state_ff == ST_DIVX) && div_rsp.done);
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (!job_empty) begin
                  job_ff   <= job_data;
                  step_ff  <= '0;
                  state_ff <= ST_MUL;
                  if (job_data.first_edge) begin
                     cross_ff <= '0;
                     mx_ff    <= '0;
                     my_ff    <= '0;
                     len_ff   <= '0;
                  end
               end
            end
            ST_MUL: begin
               step_ff <= step_ff + 1'b1;
               unique case (step_ff)
                  4'd1:    p0_ff  <= prod_ff;
                  4'd2:    c_ff   <= pacs_pkg::sat64(diff_wide);
                  4'd3:    sx_ff  <= prod_ff[63:0];
                  4'd4:    sq_ff  <= {1'b0, sx_ff} + {1'b0, prod_ff[63:0]};
                  4'd5:    t_ff   <= prod_ff;
                  4'd6:    mxt_ff <= pacs_pkg::sat64(term_wide);
                  4'd7:    t_ff   <= prod_ff;
                  4'd8: begin
                     myt_ff   <= pacs_pkg::sat64(term_wide);
                     idx_ff   <= 6'd32;
                     res_ff   <= '0;
                     rem_ff   <= '0;
                     state_ff <= ST_SQRT;
                  end
                  default: ;
               endcase
            end
            ST_SQRT: begin
               if (rem_n >= trial) begin
                  rem_ff <= rem_n - trial;
                  res_ff <= {res_ff[31:0], 1'b1};
               end else begin
                  rem_ff <= rem_n;
                  res_ff <= {res_ff[31:0], 1'b0};
               end
               idx_ff <= idx_ff - 1'b1;
               if (idx_ff == '0) state_ff <= ST_ACCUM;
            end
            ST_ACCUM: begin
               cross_ff <= pacs_pkg::sat64(99'(cross_ff) + 99'(c_ff));
               mx_ff    <= pacs_pkg::sat64(99'(mx_ff) + 99'(mxt_ff));
               my_ff    <= pacs_pkg::sat64(99'(my_ff) + 99'(myt_ff));
               len_ff   <= len_n[48] ? {48{1'b1}} : len_n[47:0];
               state_ff <= job_ff.close_edge ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
               if (degen) begin
                  cx_ff    <= '0;
                  cy_ff    <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  div_req_ff.num   <= umx;
                  div_req_ff.den   <= {2'b00, uc} + {1'b0, uc, 1'b0};
                  state_ff         <= ST_DIVX;
               end
            end
            ST_DIVX: begin
               if (div_rsp.done) begin
                  cx_ff            <= signed_mag(div_rsp.mag, mx_ff[63] ^ cross_ff[63]);
                  div_req_ff.num   <= umy;
                  state_ff         <= ST_DIVY;
               end
            end
            ST_DIVY: begin
               if (div_rsp.done) begin
                  cy_ff    <= signed_mag(div_rsp.mag, my_ff[63] ^ cross_ff[63]);
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_ff.area       <= pacs_pkg::sat32(area_wide);
                  rsp_ff.centroid_x <= cx_ff;
                  rsp_ff.centroid_y <= cy_ff;
                  rsp_ff.perimeter  <= (len_ff > 48'h0000_7FFF_FFFF) ? {31{1'b1}} : len_ff[30:0];
                  rsp_ff.degenerate <= degen;
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      prod_ff <= prod;
   end

   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished polygon not moved to the output register");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.degenerate) |->
         (rsp_ff.centroid_x == '0 && rsp_ff.centroid_y == '0 && rsp_ff.area == '0))
      else $error("degenerate result with nonzero area or centroid");

endmodule

@@ design/polygon_area_centroid_perimeter_top.sv @@
`timescale 1ns / 1ps
// top level of the polygon area, centroid and perimeter block
// depends on pacs_pkg, pacs_front, pacs_fifo, pacs_div, pacs_back
//
//  channel | direction | word                | accepted when
//  req_    | in        | one vertex          | req_valid & req_ready
//  rsp_    | out       | one polygon result  | rsp_valid & rsp_ready
//
// front takes one vertex a cycle while the edge queue is not full; after a last
// vertex that closes an open polygon it takes none until the closing edge is queued;
// the back runs each edge through the shared multiplier, square root and accumulation
// before it pops the next; a closing polygon then divides x, then y, unless degenerate
// reset is synchronous and clears all control; sums restart on each first edge
// a stalled result waits in the output register while the queue keeps filling
module polygon_area_centroid_perimeter_top #(
   parameter int QUEUE_DEPTH = pacs_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pacs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pacs_pkg::rsp_type rsp_data
);

   // front to queue
   logic               push, queue_full;
   pacs_pkg::edge_type push_data;
   // queue to back
   logic               pop, queue_empty;
   pacs_pkg::edge_type head;
   // back to divider
   pacs_pkg::div_req_type div_req;
   pacs_pkg::div_rsp_type div_rsp;

   pacs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // edges wait here so that vertex intake is not held by square roots
   pacs_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   // centroid division, one quotient bit a cycle, shared by both axes
   pacs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pacs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (head),
      .job_empty (queue_empty),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

endmodule

@@ tb/tb_polygon_area_centroid_perimeter_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for polygon_area_centroid_perimeter_top
// depends on pacs_pkg and the block's rtl; holds its own fixed-point predictor
module tb_polygon_area_centroid_perimeter_top;

   localparam int  FRAC       = pacs_pkg::CFB;
   localparam int  STALL_MAX  = 6000;        // cycles with no word moving on either side
   localparam int  DRAIN_WAIT = 600;         // covers a closing polygon in the divider
   localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
   localparam longint unsigned PERIM_CAP = 64'hFFFF_FFFF_FFFF; // 48-bit length sum

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pacs_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pacs_pkg::rsp_type rsp_data;

   polygon_area_centroid_perimeter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor state: vertices and running sums of the open polygon
   // ---------------------------------------------------------------
   longint          first_x, first_y, prev_x, prev_y;
   longint          cross_acc, moment_x_acc, moment_y_acc;
   longint unsigned perim_acc;
   bit              polygon_open;

   pacs_pkg::rsp_type pending_polygons[$];   // expected results, oldest first
   int      fail_count = 0;
   bit      calm = 1'b0;           // no idling on either side while set
   int      hold_off = 0;          // cycles the receiver must refuse for
   int      quiet_cycles = 0;

   // signed 64-bit add clamped at the bounds instead of wrapping
   function automatic longint add_clamp(longint a, longint b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
      return s[63:0];
   endfunction

   function automatic longint mul_clamp(longint a, longint b);
      logic signed [127:0] p;
      p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      if ((p[127:63] != '0) && (p[127:63] != '1)) return p[127] ? I64_MIN : I64_MAX;
      return p[63:0];
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // bit-serial integer square root of a 65-bit radicand, floor
   function automatic longint unsigned isqrt65(logic [65:0] v);
      longint unsigned root, rem, trial;
      root = 0;
      rem  = 0;
      for (int i = 32; i >= 0; i--) begin
         rem   = (rem << 2) | {v[2*i+1], v[2*i]};
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   // moment * 2^F / (3 * cross): long division, then divide by three
   function automatic logic signed [31:0] centroid_axis(longint mom, longint crs);
      longint unsigned um, uc, q, r, b;
      bit neg, sat;
      um  = magnitude(mom);
      uc  = magnitude(crs);
      q   = 0;
      r   = 0;
      sat = 1'b0;
      neg = (mom < 0) != (crs < 0);
      for (int k = 63 + FRAC; k >= 0; k--) begin
         b = (k >= FRAC) ? (um >> (k - FRAC)) & 1 : 0;
         r = (r << 1) | b;
         if (q >= 64'h4000_0000_0000_0000) begin
            sat = 1'b1;
            break;
         end
         q = q << 1;
         if (r >= uc) begin
            r = r - uc;
            q = q | 1;
         end
      end
      q = q / 3;
      if (sat || q > 64'h1_0000_0000) q = 64'h1_0000_0000;
      return clamp32(neg ? -longint'(q) : longint'(q));
   endfunction

   // one edge p -> q into the running sums
   task automatic accumulate_edge(longint px, longint py, longint qx, longint qy);
      longint          c, cs;
      longint unsigned sx, sy, lo, len;
      logic [65:0]     rad;
      c   = add_clamp(px * qy, -(py * qx));
      cs  = c >>> FRAC;
      sx  = magnitude(qx - px) * magnitude(qx - px);   // wraps like a 64-bit square
      sy  = magnitude(qy - py) * magnitude(qy - py);
      lo  = sx + sy;
      rad = {1'b0, (lo < sx), lo};
      len = isqrt65(rad);
      cross_acc    = add_clamp(cross_acc, c);
      moment_x_acc = add_clamp(moment_x_acc, mul_clamp(cs, px + qx));
      moment_y_acc = add_clamp(moment_y_acc, mul_clamp(cs, py + qy));
      perim_acc    = (len > PERIM_CAP - perim_acc) ? PERIM_CAP : perim_acc + len;
   endtask

   // runs on every accepted vertex word; queues a result when the polygon closes
   task automatic predict_vertex(pacs_pkg::req_type w);
      longint            x, y;
      pacs_pkg::rsp_type e;
      x = w.vertex_x;
      y = w.vertex_y;
      if (!polygon_open) begin
         first_x      = x;
         first_y      = y;
         cross_acc    = 0;
         moment_x_acc = 0;
         moment_y_acc = 0;
         perim_acc    = 0;
         polygon_open = 1'b1;
      end else begin
         accumulate_edge(prev_x, prev_y, x, y);
      end
      prev_x = x;
      prev_y = y;
      if (w.last_vertex) begin
         accumulate_edge(prev_x, prev_y, first_x, first_y);
         polygon_open = 1'b0;
         e.area       = clamp32(cross_acc >>> (FRAC + 1));
         e.degenerate = (cross_acc == 0);
         e.centroid_x = e.degenerate ? '0 : centroid_axis(moment_x_acc, cross_acc);
         e.centroid_y = e.degenerate ? '0 : centroid_axis(moment_y_acc, cross_acc);
         e.perimeter  = (perim_acc > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : perim_acc[30:0];
         pending_polygons.push_back(e);
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 70);
   endfunction

   // ---------------------------------------------------------------
   // sender: one vertex word, valid held until the block takes it
   // ---------------------------------------------------------------
   task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, logic last);
      int                gap;
      pacs_pkg::req_type w;
      gap = idle_len();
      w.vertex_x    = x;
      w.vertex_y    = y;
      w.last_vertex = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      predict_vertex(w);
   endtask

   // ---------------------------------------------------------------
   // receiver: random back-pressure, long hold-off on request
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      pacs_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_polygons.size() == 0) begin
            $error("result word with no polygon outstanding");
            fail_count++;
         end else begin
            e = pending_polygons.pop_front();
            if (rsp_data.area !== e.area) begin
               $error("area: expected %0d, got %0d", e.area, rsp_data.area);
               fail_count++;
            end
            if (rsp_data.centroid_x !== e.centroid_x) begin
               $error("centroid_x: expected %0d, got %0d", e.centroid_x, rsp_data.centroid_x);
               fail_count++;
            end
            if (rsp_data.centroid_y !== e.centroid_y) begin
               $error("centroid_y: expected %0d, got %0d", e.centroid_y, rsp_data.centroid_y);
               fail_count++;
            end
            if (rsp_data.perimeter !== e.perimeter) begin
               $error("perimeter: expected %0d, got %0d", e.perimeter, rsp_data.perimeter);
               fail_count++;
            end
            if (rsp_data.degenerate !== e.degenerate) begin
               $error("degenerate: expected %0d, got %0d", e.degenerate, rsp_data.degenerate);
               fail_count++;
            end
         end
      end
      // next cycle's ready
      if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 65);
      end
   end

   // watchdog: a run that stops moving words is a failure
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("tb_polygon_area_centroid_perimeter_top: FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------
   localparam logic signed [31:0] ONE  = 32'sh0001_0000;  // 1.0 in Q16.16
   localparam logic signed [31:0] MAXC = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MINC = 32'sh8000_0000;

   // lone vertex closes onto itself, so everything is zero and degenerate
   task automatic test_single_vertex();
      send_vertex(0, 0, 1'b1);
      send_vertex(MINC, MAXC, 1'b1);
   endtask

   task automatic test_two_vertices();
      send_vertex(ONE, -ONE, 1'b0);
      send_vertex(-3 * ONE, 5 * ONE, 1'b1);
   endtask

   // unit square counter-clockwise, then a clockwise triangle for negative area
   task automatic test_orientation();
      send_vertex(0, 0, 1'b0);
      send_vertex(ONE, 0, 1'b0);
      send_vertex(ONE, ONE, 1'b0);
      send_vertex(0, ONE, 1'b1);
      send_vertex(0, 0, 1'b0);
      send_vertex(0, 2 * ONE, 1'b0);
      send_vertex(3 * ONE, 0, 1'b1);
   endtask

   // collinear points give zero cross sum; a one-lsb cross sum floors to zero area
   task automatic test_degenerate_and_tiny();
      send_vertex(0, 0, 1'b0);
      send_vertex(ONE, ONE, 1'b0);
      send_vertex(2 * ONE, 2 * ONE, 1'b1);
      send_vertex(0, 0, 1'b0);
      send_vertex(1, 0, 1'b0);
      send_vertex(0, 1, 1'b1);
   endtask

   // corners of the coordinate range: sums and the perimeter saturate
   task automatic test_extremes();
      send_vertex(MINC, MINC, 1'b0);
      send_vertex(MAXC, MINC, 1'b0);
      send_vertex(MAXC, MAXC, 1'b0);
      send_vertex(MINC, MAXC, 1'b1);
   endtask

   // one random polygon: local, full range or pinned to the range edges
   task automatic random_polygon(int n);
      logic signed [31:0] cx, cy, x, y;
      int kind, spread;
      kind   = $urandom_range(0, 9);
      spread = $urandom_range(4, 24);
      cx     = $urandom;
      cy     = $urandom;
      for (int i = 0; i < n; i++) begin
         if (kind < 6) begin
            x = cx + $signed($urandom_range(0, (1 << spread) - 1)) - (1 << (spread - 1));
            y = cy + $signed($urandom_range(0, (1 << spread) - 1)) - (1 << (spread - 1));
         end else if (kind < 9) begin
            x = $urandom;
            y = $urandom;
         end else begin
            x = $urandom_range(0, 1) ? MAXC : MINC;
            y = $urandom_range(0, 1) ? MAXC : MINC;
         end
         send_vertex(x, y, i == n - 1);
      end
   endtask

   task automatic test_random(int words);
      int sent, n;
      sent = 0;
      while (sent < words) begin
         // short runs without idling now and then
         calm = ($urandom_range(0, 9) == 0);
         n    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         random_polygon(n);
         sent += n;
      end
      calm = 1'b0;
   endtask

   // receiver refuses for a long stretch while triangles keep coming
   task automatic test_backpressure();
      hold_off = 1500;
      calm     = 1'b1;
      for (int i = 0; i < 12; i++) random_polygon(3);
      calm = 1'b0;
   endtask

   initial begin
      first_x      = 0;
      first_y      = 0;
      prev_x       = 0;
      prev_y       = 0;
      cross_acc    = 0;
      moment_x_acc = 0;
      moment_y_acc = 0;
      perim_acc    = 0;
      polygon_open = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_vertex();
      test_two_vertices();
      test_orientation();
      test_degenerate_and_tiny();
      test_extremes();
      test_backpressure();
      test_random(840);

      req_valid <= 1'b0;
      while (pending_polygons.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb_polygon_area_centroid_perimeter_top: PASS");
      end else begin
         $display("tb_polygon_area_centroid_perimeter_top: FAIL");
      end
      $finish;
   end

endmodule
